[rtl/core/aes_pkg.sv]
// AES-128 package: word types, S-box, GF(2^8) helpers and round functions.
// Used by every module of the block cipher core.
package aes_pkg;

   localparam int NumRounds = 10;

   typedef struct packed {
      logic [63:0] plain_high;
      logic [63:0] plain_low;
   } req_word_type;

   typedef struct packed {
      logic [63:0] cipher_high;
      logic [63:0] cipher_low;
   } rsp_word_type;

   typedef enum logic [0:0] {
      CSR_KEY_HIGH = 1'b0,
      CSR_KEY_LOW  = 1'b1
   } csr_index_type;

   function automatic logic [7:0] sbox(input logic [7:0] a);
      logic [7:0] t [256];
      t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
      return t[a];
   endfunction

   function automatic logic [7:0] xtime(input logic [7:0] v);
      return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
   endfunction

   // byte i of the block sits at bits 127-8i
   function automatic logic [127:0] sub_shift(input logic [127:0] s);
      logic [127:0] t;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            t[127 - 8 * (4 * c + r) -: 8] = sbox(s[127 - 8 * (4 * ((c + r) % 4) + r) -: 8]);
         end
      end
      return t;
   endfunction

   function automatic logic [127:0] mix(input logic [127:0] s);
      logic [127:0] t;
      logic [7:0]   a0, a1, a2, a3, al;
      for (int c = 0; c < 4; c++) begin
         a0 = s[127 - 32 * c -: 8];
         a1 = s[119 - 32 * c -: 8];
         a2 = s[111 - 32 * c -: 8];
         a3 = s[103 - 32 * c -: 8];
         al = a0 ^ a1 ^ a2 ^ a3;
         t[127 - 32 * c -: 8] = a0 ^ al ^ xtime(a0 ^ a1);
         t[119 - 32 * c -: 8] = a1 ^ al ^ xtime(a1 ^ a2);
         t[111 - 32 * c -: 8] = a2 ^ al ^ xtime(a2 ^ a3);
         t[103 - 32 * c -: 8] = a3 ^ al ^ xtime(a3 ^ a0);
      end
      return t;
   endfunction

   function automatic logic [127:0] next_key(input logic [127:0] k, input logic [7:0] rc);
      logic [31:0]  w0, w1, w2, w3, g;
      w0 = k[127:96];
      w1 = k[95:64];
      w2 = k[63:32];
      w3 = k[31:0];
      g  = {sbox(w3[23:16]) ^ rc, sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
      w0 = w0 ^ g;
      w1 = w1 ^ w0;
      w2 = w2 ^ w1;
      w3 = w3 ^ w2;
      return {w0, w1, w2, w3};
   endfunction

endpackage

[rtl/core/aes_key_cell.sv]
// One key schedule cell: derives and holds one round key from its neighbor's.
// Depends on aes_pkg.
module aes_key_cell (
   input  logic         clock,
   input  logic         reset,
   input  logic [7:0]   rcon,
   input  logic [127:0] key_prev,
   output logic [127:0] key_out
);
   import aes_pkg::*;

   logic [127:0] key_ff, key_in;

   assign key_in  = next_key(key_prev, rcon);
   assign key_out = key_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '0;
      end else begin
         key_ff <= key_in;
      end
   end
endmodule

[rtl/core/aes_round_cell.sv]
// One cipher round cell: registered state plus valid, fed by its neighbor.
// Depends on aes_pkg.
module aes_round_cell (
   input  logic         clock,
   input  logic         reset,
   input  logic         last,
   input  logic         valid_prev,
   input  logic [127:0] state_prev,
   input  logic [127:0] round_key,
   output logic         valid_out,
   output logic [127:0] state_out
);
   import aes_pkg::*;

   logic         valid_ff;
   logic [127:0] state_ff, state_in, sh;

   assign sh       = sub_shift(state_prev);
   assign state_in = (last ? sh : mix(sh)) ^ round_key;
   assign valid_out = valid_ff;
   assign state_out = state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_prev;
      end
      state_ff <= state_in;
   end
endmodule

[rtl/core/aes128_block_encrypt.sv]
// AES-128 top level: key registers, key schedule chain, ten round cells.
// Depends on aes_pkg, aes_key_cell, aes_round_cell.
//
//   channel  ports                       direction
//   req      start, busy, req_word       in  (start & !busy)
//   rsp      rsp_strobe, rsp_word        out (one cycle, no stall)
//   csr      csr_valid/ready/index/data  in
//
// One block enters per cycle while busy is low; its ciphertext passes
// through the input key-add register and then the ten round cells.
// After reset or a key write, busy stays high while the key chain of
// ten cells settles. Reset is synchronous. Results cannot stall.
module aes128_block_encrypt (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  aes_pkg::req_word_type req_word,
   output logic                 rsp_strobe,
   output aes_pkg::rsp_word_type rsp_word,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic                 csr_index,
   input  logic [63:0]          csr_data
);
   import aes_pkg::*;

   localparam logic [7:0] Rcon [NumRounds] =
      '{8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36};

   logic [63:0]  key_high_ff, key_low_ff;
   logic [3:0]   settle_ff, settle_in;
   logic [127:0] keys [NumRounds + 1];
   logic         valid_c [NumRounds + 1];
   logic [127:0] state_c [NumRounds + 1];
   logic         v0_ff;
   logic [127:0] s0_ff;
   logic         accept, csr_write;

   assign accept    = start && !busy;
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;
   assign busy      = settle_ff != 4'd0;
   assign keys[0]   = {key_high_ff, key_low_ff};

   always_comb begin
      settle_in = settle_ff;
      if (csr_write) begin
         settle_in = 4'd11;
      end else if (settle_ff != 4'd0) begin
         settle_in = settle_ff - 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff <= '0;
         key_low_ff  <= '0;
         settle_ff   <= 4'd11;
         v0_ff       <= 1'b0;
      end else begin
         if (csr_write) begin
            unique case (csr_index_type'(csr_index))
               CSR_KEY_HIGH: key_high_ff <= csr_data;
               CSR_KEY_LOW:  key_low_ff  <= csr_data;
               default:      key_high_ff <= key_high_ff;
            endcase
         end
         settle_ff <= settle_in;
         v0_ff     <= accept;
      end
      s0_ff <= {req_word.plain_high, req_word.plain_low} ^ keys[0];
   end

   assign valid_c[0] = v0_ff;
   assign state_c[0] = s0_ff;

   for (genvar r = 0; r < NumRounds; r++) begin : g_chain
      aes_key_cell u_key (
         .clock    (clock),
         .reset    (reset),
         .rcon     (Rcon[r]),
         .key_prev (keys[r]),
         .key_out  (keys[r + 1])
      );
      aes_round_cell u_round (
         .clock      (clock),
         .reset      (reset),
         .last       (r == NumRounds - 1),
         .valid_prev (valid_c[r]),
         .state_prev (state_c[r]),
         .round_key  (keys[r + 1]),
         .valid_out  (valid_c[r + 1]),
         .state_out  (state_c[r + 1])
      );
   end

   assign rsp_strobe           = valid_c[NumRounds];
   assign rsp_word.cipher_high = state_c[NumRounds][127:64];
   assign rsp_word.cipher_low  = state_c[NumRounds][63:0];

   a_settle_bound: assert property (@(posedge clock) disable iff (reset)
      settle_ff <= 4'd11) else $error("settle counter out of range");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      csr_write |=> busy) else $error("not busy after key write");
   a_strobe_lat: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(v0_ff, 10)) else $error("strobe without item");
endmodule
